@@ design/direct_mapped_writeback_cache_defines.svh @@
// Assertion macros for the direct-mapped write-back cache.
// Used by the controller; no other dependencies.
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
`define DMC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DMC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DMC_ASSERT(label, clk, rst_n, prop, msg)
`define DMC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ design/dmc_pkg.sv @@
// Shared types and constants for the direct-mapped write-back cache.
// No dependencies.
`default_nettype none
package dmc_pkg;
	localparam int CostW = 10;
	localparam int WordW = 32;
	localparam int AcostW = 12;

	typedef struct packed {
		logic clr_step;    // clear one backing word
		logic wb_step;     // copy one line word to backing memory
		logic fill_rd;     // issue backing read for fill
		logic fill_wr;     // write returned backing word into line
		logic tag_upd;     // mark line valid/clean with new tag
		logic lookup;      // capture hit of the tag compare
		logic acc_rd;      // read requested word from line
		logic acc_wr;      // write requested word into line
		logic cnt_clr;     // clear word counter
		logic cnt_inc;     // advance word counter
		logic result;      // register result beat
	} dmc_cmd_t;

	typedef struct packed {
		logic hit;
		logic dirty;
		logic cnt_last;
		logic clr_last;
	} dmc_sts_t;
endpackage
`default_nettype wire

@@ design/dmc_datapath.sv @@
// Datapath: tag/valid/dirty arrays, line store, backing memory, cost sums.
// Depends on dmc_pkg; driven by dmc_ctrl.
`default_nettype none
module dmc_datapath import dmc_pkg::*; #(
	parameter int INDEX_BITS = 8,
	parameter int LINE_BYTES = 64,
	parameter int ADDR_BITS = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire dmc_cmd_t cmd,
	output dmc_sts_t sts,
	input wire logic in_fire,
	input wire logic action,
	input wire logic [ADDR_BITS-1:0] address,
	input wire logic [WordW-1:0] write_data,
	input wire logic [CostW-1:0] l1_read_cost,
	input wire logic [CostW-1:0] l1_write_cost,
	input wire logic [CostW-1:0] mem_read_cost,
	input wire logic [CostW-1:0] mem_write_cost,
	output logic [WordW-1:0] read_data,
	output logic hit,
	output logic wrote_back,
	output logic [AcostW-1:0] access_cost,
	output logic [WordW-1:0] total_time
);
	localparam int OffW = $clog2(LINE_BYTES);
	localparam int WpL = LINE_BYTES / 4;
	localparam int WoffW = OffW - 2;
	localparam int TagW = ADDR_BITS - OffW - INDEX_BITS;
	localparam int Lines = 1 << INDEX_BITS;
	localparam int LwW = INDEX_BITS + WoffW;
	localparam int MemW = ADDR_BITS - 2;
	localparam int LaW = ADDR_BITS - OffW;

	logic action_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [WordW-1:0] wdata_q;
	logic [WoffW-1:0] cnt_q;
	logic [MemW-1:0] clr_q;
	logic [Lines-1:0] valid_q, dirty_q;
	logic [TagW-1:0] tag_mem [Lines];
	logic [WordW-1:0] line_mem [Lines*WpL];
	logic [WordW-1:0] back_mem [1<<MemW];
	logic [TagW-1:0] vtag_q;
	logic [WordW-1:0] lrd_q, brd_q;
	logic hit_q, wb_q;
	logic [AcostW-1:0] cost_q;

	logic [INDEX_BITS-1:0] idx;
	logic [TagW-1:0] tag;
	logic [WoffW-1:0] woff;
	logic [WoffW-1:0] cnt_nx;
	logic [LaW-1:0] vline, rline;

	assign idx = addr_q[OffW +: INDEX_BITS];
	assign tag = addr_q[ADDR_BITS-1 -: TagW];
	assign woff = addr_q[2 +: WoffW];
	assign cnt_nx = cnt_q + 1'b1;
	assign vline = {vtag_q, idx};
	assign rline = addr_q[ADDR_BITS-1:OffW];

	assign sts.hit = valid_q[idx] && (vtag_q == tag);
	assign sts.dirty = valid_q[idx] && dirty_q[idx];
	assign sts.cnt_last = (cnt_q == WoffW'(WpL - 1));
	assign sts.clr_last = (clr_q == '1);

	// line and backing reads run one word ahead of the copy
	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_q <= action;
			addr_q <= address;
			wdata_q <= write_data;
			vtag_q <= tag_mem[address[OffW +: INDEX_BITS]];
		end
		lrd_q <= line_mem[{idx, cmd.acc_rd ? woff : (cmd.wb_step ? cnt_nx : cnt_q)}];
		if (cmd.clr_step)
			back_mem[clr_q] <= '0;
		else if (cmd.wb_step)
			back_mem[{vline, cnt_q}] <= lrd_q;
		if (cmd.fill_rd)
			brd_q <= back_mem[{rline, cmd.fill_wr ? cnt_nx : cnt_q}];
		if (cmd.fill_wr)
			line_mem[{idx, cnt_q}] <= brd_q;
		else if (cmd.acc_wr)
			line_mem[{idx, woff}] <= wdata_q;
		if (cmd.tag_upd)
			tag_mem[idx] <= tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			cnt_q <= '0;
			clr_q <= '0;
			hit_q <= 1'b0;
			wb_q <= 1'b0;
			cost_q <= '0;
			total_time <= '0;
			read_data <= '0;
			hit <= 1'b0;
			wrote_back <= 1'b0;
			access_cost <= '0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_q + 1'b1;
			if (cmd.cnt_clr)
				cnt_q <= '0;
			else if (cmd.cnt_inc)
				cnt_q <= cnt_q + 1'b1;
			if (in_fire) begin
				hit_q <= 1'b0;
				wb_q <= 1'b0;
				cost_q <= AcostW'(action ? l1_write_cost : l1_read_cost);
			end
			if (cmd.wb_step && sts.cnt_last) begin
				wb_q <= 1'b1;
				cost_q <= cost_q + AcostW'(mem_write_cost);
			end
			if (cmd.tag_upd) begin
				valid_q[idx] <= 1'b1;
				dirty_q[idx] <= 1'b0;
				cost_q <= cost_q + AcostW'(mem_read_cost);
			end
			if (cmd.acc_wr)
				dirty_q[idx] <= 1'b1;
			if (cmd.lookup)
				hit_q <= sts.hit;
			if (cmd.result) begin
				read_data <= action_q ? '0 : lrd_q;
				hit <= hit_q;
				wrote_back <= wb_q;
				access_cost <= cost_q;
				total_time <= total_time + WordW'(cost_q);
			end
		end
	end
endmodule
`default_nettype wire

@@ design/dmc_ctrl.sv @@
// Controller FSM: reset clear sweep, write-back, fill, access, result.
// Depends on dmc_pkg and the assertion macro header.
`default_nettype none
`include "direct_mapped_writeback_cache_defines.svh"
module dmc_ctrl import dmc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic action,
	input wire dmc_sts_t sts,
	output dmc_cmd_t cmd,
	input wire logic in_valid,
	output logic in_ready,
	output logic in_fire,
	output logic out_valid,
	input wire logic out_ready
);
	typedef enum logic [2:0] {
		CLEAR, IDLE, LOOKUP, WBACK, FILL, FILL_LAST, ACCESS, DONE
	} state_t;

	state_t state_q;
	logic act_q;
	logic fill_pend_q;

	assign in_ready = (state_q == IDLE) && (!out_valid || out_ready);
	assign in_fire = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			CLEAR: cmd.clr_step = 1'b1;
			IDLE: cmd.cnt_clr = 1'b1;
			LOOKUP: begin
				cmd.cnt_clr = 1'b1;
				cmd.lookup = 1'b1;
			end
			WBACK: begin
				cmd.wb_step = fill_pend_q;
				cmd.cnt_inc = fill_pend_q;
			end
			FILL: begin
				cmd.fill_rd = 1'b1;
				cmd.fill_wr = fill_pend_q;
				cmd.cnt_inc = fill_pend_q;
			end
			FILL_LAST: cmd.tag_upd = 1'b1;
			ACCESS: begin
				cmd.acc_rd = 1'b1;
				cmd.acc_wr = act_q;
			end
			DONE: cmd.result = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLEAR;
			act_q <= 1'b0;
			fill_pend_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				CLEAR: if (sts.clr_last) state_q <= IDLE;
				IDLE: if (in_fire) begin
					act_q <= action;
					state_q <= LOOKUP;
				end
				LOOKUP: begin
					fill_pend_q <= 1'b0;
					if (sts.hit) state_q <= ACCESS;
					else if (sts.dirty) state_q <= WBACK;
					else state_q <= FILL;
				end
				WBACK: begin
					// first cycle primes line read; counter restarts after
					if (!fill_pend_q) begin
						fill_pend_q <= 1'b1;
					end else if (sts.cnt_last) begin
						fill_pend_q <= 1'b0;
						state_q <= FILL;
					end
				end
				FILL: begin
					if (!fill_pend_q) fill_pend_q <= 1'b1;
					else if (sts.cnt_last) state_q <= FILL_LAST;
				end
				FILL_LAST: state_q <= ACCESS;
				ACCESS: state_q <= DONE;
				DONE: begin
					out_valid <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`DMC_ASSERT(a_fire_idle, clk, arst_n, in_fire |-> state_q == IDLE, "accept outside idle")
	`DMC_ASSERT(a_done_out, clk, arst_n, state_q == DONE |=> out_valid, "result not shown")
	`DMC_ASSERT_NEVER(a_wb_fill, clk, arst_n, cmd.wb_step && cmd.fill_wr, "write-back and fill overlap")
endmodule
`default_nettype wire

@@ design/direct_mapped_writeback_cache.sv @@
// Top level of the direct-mapped write-back write-allocate cache.
// Depends on dmc_pkg, dmc_ctrl and dmc_datapath.
//  channel | signals                              | dir
//  in      | in_valid/in_ready, action/address/.. | in
//  out     | out_valid/out_ready, read_data/..    | out
//  cfg     | cfg_we, cfg_index, cfg_data          | in
// A hit passes from accept through LOOKUP, ACCESS and DONE to its result; a clean
// miss first fills the line word by word from backing memory, plus FILL_LAST for
// the tag; a dirty miss first writes the old line back word by word (one backing port).
// After reset a clearing pass over all 2^(ADDR_BITS-2) words zeroes the backing
// memory; no beat is accepted during it. A new beat is taken while the
// previous result waits only once it has been delivered or is taken.
`default_nettype none
module direct_mapped_writeback_cache import dmc_pkg::*; #(
	parameter int INDEX_BITS = 8,
	parameter int LINE_BYTES = 64,
	parameter int ADDR_BITS = 20
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic action,
	input wire logic [ADDR_BITS-1:0] address,
	input wire logic [WordW-1:0] write_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [WordW-1:0] read_data,
	output logic hit,
	output logic wrote_back,
	output logic [AcostW-1:0] access_cost,
	output logic [WordW-1:0] total_time,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [CostW-1:0] cfg_data
);
	localparam logic [1:0] RegL1Rd = 2'd0;
	localparam logic [1:0] RegL1Wr = 2'd1;
	localparam logic [1:0] RegMemRd = 2'd2;
	localparam logic [1:0] RegMemWr = 2'd3;

	logic [CostW-1:0] l1_rd_q, l1_wr_q, mem_rd_q, mem_wr_q;
	dmc_cmd_t cmd;
	dmc_sts_t sts;
	logic in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_rd_q <= CostW'(1);
			l1_wr_q <= CostW'(1);
			mem_rd_q <= CostW'(100);
			mem_wr_q <= CostW'(100);
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegL1Rd: l1_rd_q <= cfg_data;
				RegL1Wr: l1_wr_q <= cfg_data;
				RegMemRd: mem_rd_q <= cfg_data;
				RegMemWr: mem_wr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dmc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .action(action), .sts(sts), .cmd(cmd),
		.in_valid(in_valid), .in_ready(in_ready), .in_fire(in_fire),
		.out_valid(out_valid), .out_ready(out_ready)
	);

	dmc_datapath #(
		.INDEX_BITS(INDEX_BITS), .LINE_BYTES(LINE_BYTES), .ADDR_BITS(ADDR_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_fire(in_fire),
		.action(action), .address(address), .write_data(write_data),
		.l1_read_cost(l1_rd_q), .l1_write_cost(l1_wr_q),
		.mem_read_cost(mem_rd_q), .mem_write_cost(mem_wr_q),
		.read_data(read_data), .hit(hit), .wrote_back(wrote_back),
		.access_cost(access_cost), .total_time(total_time)
	);
endmodule
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking bench for direct_mapped_writeback_cache: directed table plus
// random reads/writes, checked against a behavioral cache/backing memory mirror.
// Depends on dmc_pkg and the design sources.
`timescale 1ns / 1ps
module tb import dmc_pkg::*; ();

	localparam logic [1:0] CFG_L1_RD = 2'd0;
	localparam logic [1:0] CFG_L1_WR = 2'd1;
	localparam logic [1:0] CFG_MEM_RD = 2'd2;
	localparam logic [1:0] CFG_MEM_WR = 2'd3;
	localparam bit ACT_READ = 1'b0;
	localparam bit ACT_WRITE = 1'b1;
	localparam int N_RAND = 500;
	localparam int STALL_LIMIT = 1000000;

	typedef struct {
		bit [31:0] rdata;
		bit hit;
		bit wb;
		bit [11:0] cost;
		bit [31:0] total;
	} access_result_t;

	typedef struct {
		bit act;
		bit [19:0] addr;
		bit [31:0] wdata;
		bit lit;
		bit [31:0] rdata;
		bit hit;
		bit wb;
		bit [11:0] cost;
		bit [31:0] total;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic action = 0;
	logic [19:0] address = '0;
	logic [WordW-1:0] write_data = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [WordW-1:0] read_data;
	logic hit;
	logic wrote_back;
	logic [AcostW-1:0] access_cost;
	logic [WordW-1:0] total_time;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [CostW-1:0] cfg_data = '0;

	direct_mapped_writeback_cache dut (.*);

	always #5 clk = ~clk;

	// mirror of cache state
	bit line_v[256];
	bit line_d[256];
	bit [5:0] line_t[256];
	bit [31:0] line_w[4096];
	bit [31:0] mem_w[int];
	bit [31:0] elapsed;
	bit [9:0] cost_l1_rd = 1, cost_l1_wr = 1, cost_mem_rd = 100, cost_mem_wr = 100;

	access_result_t pending_results[$];
	int n_accepted = 0;
	int errors = 0;
	int stall_cycles = 0;
	bit cur_lit = 0;
	access_result_t cur_lit_res;
	bit quiet = 0;
	bit hold_req = 0;

	function automatic access_result_t cache_access(bit act, bit [19:0] a, bit [31:0] wd);
		access_result_t r;
		bit [5:0] tg;
		bit [7:0] ix;
		bit [3:0] wi;
		int vbase;
		int fbase;
		tg = a[19:14];
		ix = a[13:6];
		wi = a[5:2];
		r = '{default: 0};
		r.hit = line_v[ix] && line_t[ix] == tg;
		if (!r.hit) begin
			if (line_v[ix] && line_d[ix]) begin
				vbase = {line_t[ix], ix, 4'b0};
				for (int i = 0; i < 16; i++) mem_w[vbase + i] = line_w[{ix, 4'(i)}];
				r.wb = 1;
				r.cost += cost_mem_wr;
			end
			fbase = {tg, ix, 4'b0};
			for (int i = 0; i < 16; i++)
				line_w[{ix, 4'(i)}] = mem_w.exists(fbase + i) ? mem_w[fbase + i] : 32'h0;
			r.cost += cost_mem_rd;
			line_v[ix] = 1;
			line_d[ix] = 0;
			line_t[ix] = tg;
		end
		if (act == ACT_WRITE) begin
			line_w[{ix, wi}] = wd;
			line_d[ix] = 1;
			r.cost += cost_l1_wr;
		end else begin
			r.rdata = line_w[{ix, wi}];
			r.cost += cost_l1_rd;
		end
		elapsed = elapsed + r.cost;
		r.total = elapsed;
		return r;
	endfunction

	always @(posedge clk) begin
		access_result_t e;
		access_result_t p;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat rd=%h", read_data);
			end else begin
				e = pending_results.pop_front();
				if (read_data !== e.rdata || hit !== e.hit || wrote_back !== e.wb ||
				    access_cost !== e.cost || total_time !== e.total) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch exp rd=%h hit=%b wb=%b cost=%0d tot=%0d",
							e.rdata, e.hit, e.wb, e.cost, e.total);
						$display("         got rd=%h hit=%b wb=%b cost=%0d tot=%0d",
							read_data, hit, wrote_back, access_cost, total_time);
					end
				end
			end
		end
		if (in_valid && in_ready) begin
			p = cache_access(action, address, write_data);
			pending_results.push_back(cur_lit ? cur_lit_res : p);
			n_accepted++;
		end
	end

	// result side back-pressure
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 0;
				repeat (300) @(negedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready = 0;
				n = $urandom_range(1, 17);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready = 1;
				n = $urandom_range(1, 30);
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic wait_drained();
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_costs(bit [9:0] l1r, bit [9:0] l1w, bit [9:0] mr, bit [9:0] mw);
		wait_drained();
		cfg_we = 1;
		cfg_index = CFG_L1_RD; cfg_data = l1r; @(negedge clk);
		cfg_index = CFG_L1_WR; cfg_data = l1w; @(negedge clk);
		cfg_index = CFG_MEM_RD; cfg_data = mr; @(negedge clk);
		cfg_index = CFG_MEM_WR; cfg_data = mw; @(negedge clk);
		cfg_we = 0;
		cost_l1_rd = l1r; cost_l1_wr = l1w; cost_mem_rd = mr; cost_mem_wr = mw;
	endtask

	// called at a negedge; returns at the negedge after acceptance, or later if it adds a random idle gap
	task automatic send_beat(bit act, bit [19:0] a, bit [31:0] wd);
		int c0;
		int g;
		c0 = n_accepted;
		action = act;
		address = a;
		write_data = wd;
		in_valid = 1;
		do @(negedge clk); while (n_accepted == c0);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 0;
			g = $urandom_range(1, 17);
			repeat (g - 1) @(negedge clk);
		end
	endtask

	function automatic bit [19:0] rand_addr();
		bit [5:0] tg;
		bit [7:0] ix;
		if ($urandom_range(0, 9) < 3) return 20'($urandom);
		tg = 6'($urandom_range(0, 3));
		if ($urandom_range(0, 1)) tg = ~tg;
		ix = 8'($urandom_range(0, 3));
		if ($urandom_range(0, 3) == 0) ix = ~ix;
		return {tg, ix, 6'($urandom)};
	endfunction

	stim_row_t directed[12] = '{
		'{ACT_READ,  20'h00000, 32'h0,        1, 32'h0,        0, 0, 12'd101, 32'd101},
		'{ACT_READ,  20'h00000, 32'h0,        1, 32'h0,        1, 0, 12'd1,   32'd102},
		'{ACT_WRITE, 20'h00003, 32'hFFFFFFFF, 1, 32'h0,        1, 0, 12'd1,   32'd103},
		'{ACT_READ,  20'h00000, 32'h0,        1, 32'hFFFFFFFF, 1, 0, 12'd1,   32'd104},
		'{ACT_WRITE, 20'hFC03C, 32'h12345678, 1, 32'h0,        0, 1, 12'd201, 32'd305},
		'{ACT_READ,  20'h00000, 32'h0,        0, 32'h0,        0, 0, 12'd0,   32'd0},
		'{ACT_READ,  20'hFFFFF, 32'h0,        0, 32'h0,        0, 0, 12'd0,   32'd0},
		'{ACT_WRITE, 20'hFFFFC, 32'h00000000, 0, 32'h0,        0, 0, 12'd0,   32'd0},
		'{ACT_READ,  20'hFC03F, 32'h0,        0, 32'h0,        0, 0, 12'd0,   32'd0},
		'{ACT_WRITE, 20'h03FC0, 32'hA5A5A5A5, 0, 32'h0,        0, 0, 12'd0,   32'd0},
		'{ACT_READ,  20'h03FC1, 32'h0,        0, 32'h0,        0, 0, 12'd0,   32'd0},
		'{ACT_WRITE, 20'h00040, 32'h5A5A5A5A, 0, 32'h0,        0, 0, 12'd0,   32'd0}
	};

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (directed[i]) begin
			cur_lit = directed[i].lit;
			cur_lit_res = '{directed[i].rdata, directed[i].hit, directed[i].wb,
				directed[i].cost, directed[i].total};
			send_beat(directed[i].act, directed[i].addr, directed[i].wdata);
		end
		in_valid = 0;
		cur_lit = 0;
		for (int i = 0; i < N_RAND; i++) begin
			if (i % 100 == 0) begin
				in_valid = 0;
				case (i / 100)
					0: write_costs(10'd0, 10'd0, 10'd0, 10'd0);
					1: write_costs(10'd1023, 10'd1023, 10'd1023, 10'd1023);
					2: write_costs(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
					3: write_costs(10'd1, 10'd1, 10'd100, 10'd100);
					default: write_costs(10'd5, 10'd3, 10'd1023, 10'd0);
				endcase
			end
			if (i == 120) hold_req = 1;
			if (i == 260) begin
				in_valid = 0;
				while (pending_results.size() != 0) @(negedge clk);
			end
			if (i == 450) quiet = 1;
			send_beat($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, rand_addr(), $urandom);
		end
		in_valid = 0;
		wait_drained();
		repeat (100) @(negedge clk);
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end
endmodule
